// File: hdl/kpvf_pkg.sv
// ----------------------------------------------------------------------------
// kpvf_pkg: shared types and constants for the position/velocity filter
// Request and response payloads, CSR indexes and controller commands.
// ----------------------------------------------------------------------------
package kpvf_pkg;

   localparam int DT_FRAC = 16;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] acceleration;
      logic        [15:0] time_step;
      logic signed [31:0] measured_position;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] position_estimate;
      logic signed [31:0] velocity_estimate;
   } rsp_payload_type;

   localparam logic [1:0] CSR_QX = 2'd0;
   localparam logic [1:0] CSR_QV = 2'd1;
   localparam logic [1:0] CSR_R  = 2'd2;

   // datapath operations, one per micro-step
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_AD,
      OP_HALF,
      OP_DP11,
      OP_INNER,
      OP_VDT,
      OP_IDT,
      OP_PRED_WB,
      OP_UPD_PRE,
      OP_DIV0_START,
      OP_DIV0_END,
      OP_DIV1_START,
      OP_DIV1_END,
      OP_K0Y,
      OP_K1Y,
      OP_K0P00,
      OP_K0P01,
      OP_K1P00,
      OP_K1P01,
      OP_UPD_WB
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

endpackage

// File: hdl/kpvf_datapath.sv
// ----------------------------------------------------------------------------
// kpvf_datapath: filter state, shared multiplier and serial divider
// One multiply per step into a registered product; restoring divider.
// ----------------------------------------------------------------------------
module kpvf_datapath #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kpvf_pkg::cmd_type        cmd,
   output kpvf_pkg::status_type     status,
   input  kpvf_pkg::req_payload_type req,
   input  logic                     csr_we,
   input  logic [1:0]               csr_idx,
   input  logic [30:0]              csr_data,
   output kpvf_pkg::rsp_payload_type result
);
   import kpvf_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int PW  = 2 * W + 1;
   localparam int NW  = W + FRAC_BITS;
   localparam int QW  = NW + 1;
   localparam int CW  = $clog2(NW + 1);
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = W'(1) << FRAC_BITS;

   logic signed [W-1:0] x_ff, x_in, v_ff, v_in;
   logic signed [W-1:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [W-1:0] qx_ff, qx_in, qv_ff, qv_in, r_ff, r_in;
   logic signed [W-1:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic signed [W-1:0] t4_ff, t4_in, t5_ff, t5_in, t6_ff, t6_in;
   logic signed [W-1:0] acc_ff, z_ff;
   logic        [15:0]  dt_ff;
   logic signed [W-1:0] ma, mb, mres;
   logic                mdt;

   // divider
   logic [NW-1:0] dnum_ff, dnum_in;
   logic [W-1:0]  dden_ff, dden_in;
   logic [W:0]    drem_ff, drem_in;
   logic [QW-1:0] dq_ff, dq_in;
   logic          dneg_ff, dneg_in, dbusy_ff, dbusy_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic [W:0]    rsh;
   logic signed [W-1:0] dres;

   function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
      if (v > $signed({2'b00, SMAX})) return SMAX;
      if (v < $signed({{2{1'b1}}, SMIN})) return SMIN;
      return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] adds(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      return sat(W'(0) + {{2{a[W-1]}}, a} + {{2{b[W-1]}}, b});
   endfunction

   function automatic logic signed [W-1:0] subs(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      return sat({{2{a[W-1]}}, a} - {{2{b[W-1]}}, b});
   endfunction

   function automatic logic signed [31:0] o32(input logic signed [W-1:0] v);
      logic signed [W+31:0] e;
      e = {{32{v[W-1]}}, v};
      if (e > 64'sh7fffffff) return 32'sh7fffffff;
      if (e < -64'sh80000000) return 32'sh80000000;
      return e[31:0];
   endfunction

   // 32-bit input field into the state format, clamped when narrower
   function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
      logic signed [W+31:0] e, hi, lo;
      e = (W+32)'(v);
      hi = (W+32)'(SMAX);
      lo = (W+32)'(SMIN);
      if (e > hi) return SMAX;
      if (e < lo) return SMIN;
      return e[W-1:0];
   endfunction

   // multiplier: floor(a*b >> s), saturated
   always_comb begin
      logic signed [PW-1:0] p, sh;
      p = $signed({{(W+1){ma[W-1]}}, ma}) * $signed({{(W+1){mb[W-1]}}, mb});
      sh = mdt ? (p >>> DT_FRAC) : (p >>> FRAC_BITS);
      if (sh > $signed({{(PW-W){1'b0}}, SMAX})) mres = SMAX;
      else if (sh < $signed({{(PW-W){1'b1}}, SMIN})) mres = SMIN;
      else mres = sh[W-1:0];
   end

   logic signed [W-1:0] dtw;
   assign dtw = W'(dt_ff);

   always_comb begin
      ma = t0_ff; mb = dtw; mdt = 1'b1;
      case (cmd.op)
         OP_AD:    begin ma = acc_ff; mb = dtw; end
         OP_HALF:  begin ma = t0_ff;  mb = dtw; end
         OP_DP11:  begin ma = p11_ff; mb = dtw; end
         OP_VDT:   begin ma = v_ff;   mb = dtw; end
         OP_IDT:   begin ma = t3_ff;  mb = dtw; end
         OP_K0Y:   begin ma = t4_ff; mb = t2_ff; mdt = 1'b0; end
         OP_K1Y:   begin ma = t5_ff; mb = t2_ff; mdt = 1'b0; end
         OP_K0P00: begin ma = t4_ff; mb = p00_ff; mdt = 1'b0; end
         OP_K0P01: begin ma = t4_ff; mb = p01_ff; mdt = 1'b0; end
         OP_K1P00: begin ma = t5_ff; mb = p00_ff; mdt = 1'b0; end
         OP_K1P01: begin ma = t5_ff; mb = p01_ff; mdt = 1'b0; end
         default:  ;
      endcase
   end

   // divider step
   assign rsh = {drem_ff[W-1:0], dnum_ff[NW-1]};
   always_comb begin
      logic [QW-1:0] lim;
      lim = QW'(1) << (W - 1);
      if (dq_ff > lim) dres = dneg_ff ? SMIN : SMAX;
      else if (!dneg_ff && dq_ff == lim) dres = SMAX;
      else if (dneg_ff) dres = W'(-dq_ff);
      else dres = dq_ff[W-1:0];
   end

   always_comb begin
      x_in = x_ff; v_in = v_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      qx_in = qx_ff; qv_in = qv_ff; r_in = r_ff;
      t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff;
      t4_in = t4_ff; t5_in = t5_ff; t6_in = t6_ff;
      dnum_in = dnum_ff; dden_in = dden_ff; drem_in = drem_ff; dq_in = dq_ff;
      dneg_in = dneg_ff; dbusy_in = dbusy_ff; dcnt_in = dcnt_ff;
      if (csr_we) begin
         unique case (csr_idx)
            CSR_QX:  qx_in = sat((W+2)'(csr_data));
            CSR_QV:  qv_in = sat((W+2)'(csr_data));
            CSR_R:   r_in  = sat((W+2)'(csr_data));
            default: ;
         endcase
      end
      if (dbusy_ff) begin
         if (rsh >= {1'b0, dden_ff}) begin
            drem_in = rsh - {1'b0, dden_ff};
            dq_in = {dq_ff[QW-2:0], 1'b1};
         end else begin
            drem_in = rsh;
            dq_in = {dq_ff[QW-2:0], 1'b0};
         end
         dnum_in = {dnum_ff[NW-2:0], 1'b0};
         dcnt_in = dcnt_ff - CW'(1);
         if (dcnt_ff == CW'(1)) dbusy_in = 1'b0;
      end
      case (cmd.op)
         OP_AD:    t0_in = mres;
         OP_HALF:  t1_in = mres >>> 1;
         OP_DP11:  t2_in = mres;
         OP_INNER: t3_in = adds(adds(p10_ff, p01_ff), t2_ff);
         OP_VDT:   t4_in = mres;
         OP_IDT:   t5_in = mres;
         OP_PRED_WB: begin
            x_in = adds(x_ff, adds(t4_ff, t1_ff));
            v_in = adds(v_ff, t0_ff);
            p00_in = adds(adds(p00_ff, t5_ff), qx_ff);
            p01_in = adds(p01_ff, t2_ff);
            p10_in = adds(p10_ff, t2_ff);
            p11_in = adds(p11_ff, qv_ff);
         end
         OP_UPD_PRE: begin
            t2_in = subs(z_ff, x_ff);
            t3_in = adds(p00_ff, r_ff);
            t4_in = '0;
            t5_in = '0;
         end
         OP_DIV0_START, OP_DIV1_START: begin
            logic signed [W-1:0] n;
            logic [W-1:0] un;
            n = (cmd.op == OP_DIV0_START) ? p00_ff : p10_ff;
            un = n[W-1] ? W'(-n) : n;
            if (t3_ff > 0) begin
               dnum_in = {un, {FRAC_BITS{1'b0}}};
               dden_in = t3_ff;
               drem_in = '0;
               dq_in = '0;
               dneg_in = n[W-1];
               dcnt_in = CW'(NW);
               dbusy_in = 1'b1;
            end
         end
         OP_DIV0_END: if (t3_ff > 0) t4_in = dres;
         OP_DIV1_END: if (t3_ff > 0) t5_in = dres;
         OP_K0Y:   t0_in = mres;
         OP_K1Y:   t1_in = mres;
         OP_K0P00: t6_in = mres;
         OP_K0P01: t3_in = mres;
         OP_K1P00: t2_in = mres;
         OP_K1P01: begin
            x_in = adds(x_ff, t0_ff);
            v_in = adds(v_ff, t1_ff);
            p00_in = subs(p00_ff, t6_ff);
            p01_in = subs(p01_ff, t3_ff);
            p10_in = subs(p10_ff, t2_ff);
            p11_in = subs(p11_ff, mres);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0; v_ff <= '0;
         p00_ff <= ONE; p01_ff <= '0; p10_ff <= '0; p11_ff <= ONE;
         qx_ff <= W'((ONE + 50) / 100);
         qv_ff <= W'((ONE + 5) / 10);
         r_ff <= ONE >>> 1;
         dbusy_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         x_ff <= x_in; v_ff <= v_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
         qx_ff <= qx_in; qv_ff <= qv_in; r_ff <= r_in;
         dbusy_ff <= dbusy_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff <= t0_in; t1_ff <= t1_in; t2_ff <= t2_in; t3_ff <= t3_in;
      t4_ff <= t4_in; t5_ff <= t5_in; t6_ff <= t6_in;
      dnum_ff <= dnum_in; dden_ff <= dden_in; drem_ff <= drem_in; dq_ff <= dq_in;
      dneg_ff <= dneg_in;
      if (cmd.op == OP_LOAD) begin
         acc_ff <= sat_in(req.acceleration);
         z_ff   <= sat_in(req.measured_position);
         dt_ff  <= req.time_step;
      end
   end

   assign status.div_busy = dbusy_ff;
   assign result.position_estimate = o32(x_ff);
   assign result.velocity_estimate = o32(v_ff);

endmodule

// File: hdl/kpvf_control.sv
// ----------------------------------------------------------------------------
// kpvf_control: sequencer for predict and update
// Issues one datapath operation per cycle, waits on the divider.
// ----------------------------------------------------------------------------
module kpvf_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  kpvf_pkg::status_type status,
   output kpvf_pkg::cmd_type    cmd
);
   import kpvf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PRED = 5'b00010,
      ST_UPD  = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       second_ff, second_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff; step_in = step_ff; second_in = second_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.op = OP_LOAD;
            step_in = '0;
            state_in = req_kind ? ST_UPD : ST_PRED;
         end
         ST_PRED: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: cmd.op = OP_AD;
               4'd1: cmd.op = OP_HALF;
               4'd2: cmd.op = OP_DP11;
               4'd3: cmd.op = OP_INNER;
               4'd4: cmd.op = OP_VDT;
               4'd5: cmd.op = OP_IDT;
               default: begin
                  cmd.op = OP_PRED_WB;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_UPD: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: cmd.op = OP_UPD_PRE;
               4'd1: begin
                  cmd.op = OP_DIV0_START;
                  second_in = 1'b0;
                  state_in = ST_WAIT;
               end
               4'd2: begin
                  cmd.op = OP_DIV1_START;
                  second_in = 1'b1;
                  state_in = ST_WAIT;
               end
               4'd3: cmd.op = OP_K0Y;
               4'd4: cmd.op = OP_K1Y;
               4'd5: cmd.op = OP_K0P00;
               4'd6: cmd.op = OP_K0P01;
               4'd7: cmd.op = OP_K1P00;
               default: begin
                  cmd.op = OP_K1P01;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_WAIT: if (!status.div_busy) begin
            cmd.op = second_ff ? OP_DIV1_END : OP_DIV0_END;
            state_in = ST_UPD;
         end
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         second_ff <= second_in;
      end
   end

endmodule

// File: hdl/kalman_position_velocity_filter_core.sv
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_core: two-state Kalman filter
// Tracks position and velocity in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: a request transfer (req_valid high, req_stall low) carries one item;
// req_type 0 predicts with acceleration and time_step, 1 corrects with
// measured_position. Each item yields one response transfer with the new
// position and velocity estimates.
// One item at a time. An update waits on the bit-serial divider, which
// forms both gains in turn. Products go through one shared multiplier,
// at most one per cycle.
// req_stall stays high from acceptance until the response is taken. A stalled
// response holds its payload; the next request waits for it.
// CSR writes (csr_valid and csr_ready) are accepted any cycle; csr_ready is
// always high. Writes to unknown indexes are dropped.
// Reset clears the estimates, sets the covariance to identity and the noise
// registers to 0.01, 0.1 and 0.5.
// ----------------------------------------------------------------------------
module kalman_position_velocity_filter_core #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  kpvf_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output kpvf_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [30:0]                csr_data
);
   import kpvf_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   kpvf_control u_control (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_kind (req_payload.req_type),
      .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   kpvf_datapath #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock, .reset,
      .cmd, .status,
      .req (req_payload),
      .csr_we (csr_valid & csr_ready),
      .csr_idx (csr_index),
      .csr_data,
      .result (rsp_payload)
   );

endmodule
